[src/smpq_pkg.sv]
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared sizes, request codes and the result bundle of the sorted min queue.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_WIDTH = 32;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int KIND_W     = 2;
	localparam int KEY_PORT_W = 32;
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 5;

	localparam int S_TDATA_W = ((KEY_PORT_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

	typedef struct packed {
		logic                 ok;
		logic [KEY_WIDTH-1:0] value;
		logic [CNT_W-1:0]     count;
	} res_t;

endpackage

`default_nettype wire

[src/smpq_ram.sv]
// ----------------------------------------------------------------------------
// smpq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[src/smpq_engine.sv]
// ----------------------------------------------------------------------------
// smpq_engine
// Request sequencer: keeps the keys as a sorted ring in RAM, shifts for insert.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_engine (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output      logic                               in_ready,
	input  wire logic [smpq_pkg::KIND_W-1:0]        in_kind,
	input  wire logic [smpq_pkg::KEY_WIDTH-1:0]     in_key,
	output      logic                               res_valid,
	input  wire logic                               res_ready,
	output      smpq_pkg::res_t                     res,
	output      logic                               ram_we,
	output      logic [smpq_pkg::IDX_W-1:0]         ram_waddr,
	output      logic [smpq_pkg::KEY_WIDTH-1:0]     ram_wdata,
	output      logic                               ram_re,
	output      logic [smpq_pkg::IDX_W-1:0]         ram_raddr,
	input  wire logic [smpq_pkg::KEY_WIDTH-1:0]     ram_rdata
);

	import smpq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_INS,
		ST_LAST,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     pos_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KIND_W-1:0]    kind_q;
	res_t                 res_q;

	// Ring position of a logical slot counted from the head.
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
	                                          input logic [CNT_W-1:0] l);
		logic [CNT_W:0] s;
		s = {{(CNT_W + 1 - IDX_W){1'b0}}, h} + {1'b0, l};
		if (s >= (CNT_W + 1)'(DEPTH)) begin
			s = s - (CNT_W + 1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res       = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_kind)
						KIND_INSERT: begin
							if (count_q == '0) begin
								ram_we    = 1'b1;
								ram_waddr = head_q;
								ram_wdata = in_key;
							end else if (count_q != CNT_W'(DEPTH)) begin
								ram_re    = 1'b1;
								ram_raddr = phys(head_q, count_q - CNT_W'(1));
							end
						end
						KIND_REMOVE, KIND_PEEK: begin
							if (count_q != '0) begin
								ram_re    = 1'b1;
								ram_raddr = head_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, pos_q);
				if (key_q < ram_rdata) begin
					ram_wdata = ram_rdata;
					if (pos_q != CNT_W'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = phys(head_q, pos_q - CNT_W'(2));
					end
				end else begin
					ram_wdata = key_q;
				end
			end
			ST_LAST: begin
				ram_we    = 1'b1;
				ram_waddr = head_q;
				ram_wdata = key_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			pos_q   <= '0;
			key_q   <= '0;
			kind_q  <= KIND_INSERT;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q  <= in_key;
						kind_q <= in_kind;
						case (in_kind)
							KIND_INSERT: begin
								if (count_q == CNT_W'(DEPTH)) begin
									res_q   <= '{ok: 1'b0, value: '0, count: count_q};
									state_q <= ST_RESP;
								end else if (count_q == '0) begin
									count_q <= CNT_W'(1);
									res_q   <= '{ok: 1'b1, value: '0, count: CNT_W'(1)};
									state_q <= ST_RESP;
								end else begin
									pos_q   <= count_q;
									state_q <= ST_INS;
								end
							end
							KIND_REMOVE, KIND_PEEK: begin
								if (count_q == '0) begin
									res_q   <= '{ok: 1'b0, value: '0, count: count_q};
									state_q <= ST_RESP;
								end else begin
									state_q <= ST_HEAD;
								end
							end
							default: begin
								res_q   <= '{ok: 1'b0, value: '0, count: count_q};
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_HEAD: begin
					if (kind_q == KIND_REMOVE) begin
						head_q  <= phys(head_q, CNT_W'(1));
						count_q <= count_q - CNT_W'(1);
						res_q   <= '{ok: 1'b1, value: ram_rdata, count: count_q - CNT_W'(1)};
					end else begin
						res_q   <= '{ok: 1'b1, value: ram_rdata, count: count_q};
					end
					state_q <= ST_RESP;
				end
				ST_INS: begin
					if (key_q < ram_rdata) begin
						if (pos_q == CNT_W'(1)) begin
							state_q <= ST_LAST;
						end else begin
							pos_q <= pos_q - CNT_W'(1);
						end
					end else begin
						count_q <= count_q + CNT_W'(1);
						res_q   <= '{ok: 1'b1, value: '0, count: count_q + CNT_W'(1)};
						state_q <= ST_RESP;
					end
				end
				ST_LAST: begin
					count_q <= count_q + CNT_W'(1);
					res_q   <= '{ok: 1'b1, value: '0, count: count_q + CNT_W'(1)};
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[src/sorted_min_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Min priority queue kept as a sorted ring of keys in one synchronous RAM.
// ----------------------------------------------------------------------------
//  Channel  Dir  Fields (lowest bit first)
//  s_*      in   tuser: kind[1:0]; tdata: key[31:0]
//  m_*      out  tuser: ok[0]; tdata: value[31:0], count[36:32], zero fill
//
// One request is handled at a time. A refused or unknown request, or an insert
// into an empty queue, goes straight to its result; a peek or remove first does
// one RAM read of the head; any other insert moves each larger key up a slot.
// Reset clears the count and the head pointer; RAM contents are not cleared.
// A result waits in the output register; the sequencer stalls when it is full.
`default_nettype none

module sorted_min_priority_queue (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [smpq_pkg::S_TDATA_W-1:0]     s_tdata,  // key
	input  wire logic [smpq_pkg::KIND_W-1:0]        s_tuser,  // kind
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	output      logic [smpq_pkg::M_TDATA_W-1:0]     m_tdata,  // value, count
	output      logic                               m_tuser   // ok
);

	import smpq_pkg::*;

	logic                 res_valid;
	logic                 res_ready;
	res_t                 res;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [KEY_WIDTH-1:0] ram_wdata;
	logic                 ram_re;
	logic [IDX_W-1:0]     ram_raddr;
	logic [KEY_WIDTH-1:0] ram_rdata;

	logic [KEY_PORT_W+KEY_WIDTH-1:0] key_ext;
	logic [KEY_WIDTH+VALUE_W-1:0]    value_ext;
	logic [CNT_W+COUNT_W-1:0]        count_ext;

	logic               out_valid_q;
	logic               out_ok_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [COUNT_W-1:0] out_count_q;

	assign key_ext   = {{KEY_WIDTH{1'b0}}, s_tdata[KEY_PORT_W-1:0]};
	assign value_ext = {{VALUE_W{1'b0}}, res.value};
	assign count_ext = {{COUNT_W{1'b0}}, res.count};

	assign res_ready = !out_valid_q || m_tready;

	smpq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_key    (key_ext[KEY_WIDTH-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	smpq_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_ok_q    <= 1'b0;
			out_value_q <= '0;
			out_count_q <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_ok_q    <= res.ok;
				out_value_q <= value_ext[VALUE_W-1:0];
				out_count_q <= count_ext[COUNT_W-1:0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}}, out_count_q, out_value_q};

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted min priority queue. A short table of
// requests covers empty and full refusals, unknown kinds and extreme keys.
// Random fill-heavy, drain-heavy and mixed runs follow under four flow-control
// phases. Every result is checked against a local model or its table row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import smpq_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
	localparam int PHASE_ITEMS  = 175;
	localparam int N_DIRECTED   = 25;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [KEY_PORT_W-1:0] key;
		logic                  typed;
		res_t                  want;
	} request_row_t;

	localparam request_row_t DIRECTED_REQUESTS [N_DIRECTED] = '{
		'{KIND_REMOVE,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 5'd0}},
		'{KIND_PEEK,    32'h0000_0000, 1'b1, '{1'b0, 32'h0, 5'd0}},
		'{KIND_UNKNOWN, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 5'd0}},
		'{KIND_INSERT,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 5'd1}},
		'{KIND_INSERT,  32'h0000_0000, 1'b1, '{1'b1, 32'h0, 5'd2}},
		'{KIND_PEEK,    32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 5'd2}},
		'{KIND_UNKNOWN, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 5'd2}},
		'{KIND_INSERT,  32'h0000_0007, 1'b0, '0},
		'{KIND_INSERT,  32'h0000_0007, 1'b0, '0},
		'{KIND_INSERT,  32'h0000_0003, 1'b0, '0},
		'{KIND_REMOVE,  32'h0000_0000, 1'b0, '0},
		'{KIND_INSERT,  32'h8000_0000, 1'b0, '0},
		'{KIND_INSERT,  32'h7FFF_FFFF, 1'b0, '0},
		'{KIND_INSERT,  32'h0000_0001, 1'b0, '0},
		'{KIND_INSERT,  32'hFFFF_FFFE, 1'b0, '0},
		'{KIND_INSERT,  32'h0000_0007, 1'b0, '0},
		'{KIND_INSERT,  32'hAAAA_AAAA, 1'b0, '0},
		'{KIND_INSERT,  32'h5555_5555, 1'b0, '0},
		'{KIND_INSERT,  32'h0000_0003, 1'b0, '0},
		'{KIND_INSERT,  32'h0000_0000, 1'b0, '0},
		'{KIND_INSERT,  32'hFFFF_FFFF, 1'b0, '0},
		'{KIND_INSERT,  32'h1234_5678, 1'b0, '0},
		'{KIND_INSERT,  32'h0000_0007, 1'b0, '0},
		'{KIND_INSERT,  32'h0000_0009, 1'b1, '{1'b0, 32'h0, 5'd16}},
		'{KIND_PEEK,    32'h0000_0000, 1'b0, '0}
	};

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata  = '0;
	logic [KIND_W-1:0]      s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tuser;

	logic [KEY_WIDTH-1:0]   model_keys [DEPTH];
	int                     model_fill = 0;
	res_t                   pending_results [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int stall_cycles   = 0;
	int n_insert = 0, n_remove = 0, n_peek = 0, n_unknown = 0;
	int n_full_refused = 0, n_empty_refused = 0, n_results = 0;

	sorted_min_priority_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic res_t apply_request(input logic [KIND_W-1:0] kind,
			input logic [KEY_PORT_W-1:0] key);
		res_t                 r;
		logic [KEY_WIDTH-1:0] k;
		int                   pos;
		r = '0;
		k = key[KEY_WIDTH-1:0];
		if (kind == KIND_INSERT) begin
			if (model_fill < DEPTH) begin
				pos = model_fill;
				while (pos > 0 && k < model_keys[pos-1]) begin
					model_keys[pos] = model_keys[pos-1];
					pos--;
				end
				model_keys[pos] = k;
				model_fill++;
				r.ok = 1'b1;
			end
		end else if (kind == KIND_REMOVE || kind == KIND_PEEK) begin
			if (model_fill > 0) begin
				r.ok    = 1'b1;
				r.value = model_keys[0];
				if (kind == KIND_REMOVE) begin
					for (int i = 0; i + 1 < model_fill; i++)
						model_keys[i] = model_keys[i+1];
					model_fill--;
				end
			end
		end
		r.count = model_fill[CNT_W-1:0];
		return r;
	endfunction

	task automatic send_request(input logic [KIND_W-1:0] kind,
			input logic [KEY_PORT_W-1:0] key, input logic typed, input res_t want);
		int   gap;
		res_t predicted;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= key;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = apply_request(kind, key);
		pending_results.push_back(typed ? want : predicted);
		case (kind)
			KIND_INSERT: begin
				n_insert++;
				if (!predicted.ok)
					n_full_refused++;
			end
			KIND_REMOVE, KIND_PEEK: begin
				if (kind == KIND_REMOVE)
					n_remove++;
				else
					n_peek++;
				if (!predicted.ok)
					n_empty_refused++;
			end
			default: n_unknown++;
		endcase
	endtask

	function automatic logic [KEY_PORT_W-1:0] random_key();
		case ($urandom_range(9))
			0, 1, 2, 3: return KEY_PORT_W'($urandom_range(7));
			4: begin
				case ($urandom_range(3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$error("result word with no request pending: ok %0b value %h count %0d",
					m_tuser, m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: COUNT_W]);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.ok) begin
					$error("ok: expected %0b, actual %0b", want.ok, m_tuser);
					error_count++;
				end
				if (m_tdata[VALUE_W-1:0] !== want.value) begin
					$error("value: expected %h, actual %h", want.value,
						m_tdata[VALUE_W-1:0]);
					error_count++;
				end
				if (m_tdata[VALUE_W +: COUNT_W] !== want.count) begin
					$error("count: expected %0d, actual %0d", want.count,
						m_tdata[VALUE_W +: COUNT_W]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int                   seg_left;
		int                   mode;
		int                   r;
		logic [KIND_W-1:0]    kind;
		seg_left = 0;
		mode     = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_request(DIRECTED_REQUESTS[i].kind, DIRECTED_REQUESTS[i].key,
				DIRECTED_REQUESTS[i].typed, DIRECTED_REQUESTS[i].want);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (seg_left == 0) begin
					mode     = $urandom_range(2);
					seg_left = $urandom_range(10, 40);
				end
				seg_left--;
				r = $urandom_range(99);
				if (r < 3)
					kind = KIND_UNKNOWN;
				else begin
					case (mode)
						0: kind = (r < 73) ? KIND_INSERT : (r < 90) ? KIND_REMOVE : KIND_PEEK;
						1: kind = (r < 30) ? KIND_INSERT : (r < 80) ? KIND_REMOVE : KIND_PEEK;
						default:
							kind = (r < 50) ? KIND_INSERT : (r < 80) ? KIND_REMOVE : KIND_PEEK;
					endcase
				end
				send_request(kind, random_key(), 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d inserts, %0d removes, %0d peeks and %0d unknown requests; %0d results.",
			n_insert, n_remove, n_peek, n_unknown, n_results);
		$display("Inserts refused on a full queue: %0d; removes or peeks on an empty one: %0d.",
			n_full_refused, n_empty_refused);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

[sorted_min_priority_queue.f]
src/smpq_pkg.sv
src/smpq_ram.sv
src/smpq_engine.sv
src/sorted_min_priority_queue.sv
tb/sv/tb_top.sv
